// ----- sv/stl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the source text tokenizer.
// Lexer modes, token kinds, error codes and the keyword table. No dependencies.
package stl_pkg;

  typedef enum logic [14:0] {
    M_IDLE      = 15'b000000000000001,
    M_IDENT     = 15'b000000000000010,
    M_INT       = 15'b000000000000100,
    M_FRAC      = 15'b000000000001000,
    M_STR       = 15'b000000000010000,
    M_STR_ESC   = 15'b000000000100000,
    M_CHR0      = 15'b000000001000000,
    M_CHR_ESC   = 15'b000000010000000,
    M_CHR_CLOSE = 15'b000000100000000,
    M_COMMENT   = 15'b000001000000000,
    M_LT        = 15'b000010000000000,
    M_COLON     = 15'b000100000000000,
    M_MINUS     = 15'b001000000000000,
    M_AMP       = 15'b010000000000000,
    M_PIPE      = 15'b100000000000000
  } mode_t;

  localparam int NUM_KW = 13;
  localparam int KW_MAX = 6;

  typedef logic [5:0] kind_t;
  typedef logic [2:0] err_t;
  typedef logic [7:0] byte_t;

  localparam kind_t K_EOF     = 6'd0;
  localparam kind_t K_IDENT   = 6'd1;
  localparam kind_t K_KW0     = 6'd2;
  localparam kind_t K_INT     = 6'd15;
  localparam kind_t K_FLOAT   = 6'd16;
  localparam kind_t K_STR     = 6'd17;
  localparam kind_t K_CHAR    = 6'd18;
  localparam kind_t K_UNKNOWN = 6'd19;
  localparam kind_t K_LPAREN  = 6'd20;
  localparam kind_t K_RPAREN  = 6'd21;
  localparam kind_t K_LBRACE  = 6'd22;
  localparam kind_t K_RBRACE  = 6'd23;
  localparam kind_t K_LBRACK  = 6'd24;
  localparam kind_t K_RBRACK  = 6'd25;
  localparam kind_t K_DOT     = 6'd26;
  localparam kind_t K_SEMI    = 6'd27;
  localparam kind_t K_COMMA   = 6'd28;
  localparam kind_t K_PERCENT = 6'd29;
  localparam kind_t K_CARET   = 6'd30;
  localparam kind_t K_PLUS    = 6'd31;
  localparam kind_t K_STAR    = 6'd32;
  localparam kind_t K_SLASH   = 6'd33;
  localparam kind_t K_EQ      = 6'd34;
  localparam kind_t K_GT      = 6'd35;
  localparam kind_t K_LT      = 6'd36;
  localparam kind_t K_NE      = 6'd37;
  localparam kind_t K_COLON   = 6'd38;
  localparam kind_t K_DCOLON  = 6'd39;
  localparam kind_t K_MINUS   = 6'd40;
  localparam kind_t K_ARROW   = 6'd41;
  localparam kind_t K_AMP     = 6'd42;
  localparam kind_t K_ANDAND  = 6'd43;
  localparam kind_t K_PIPE    = 6'd44;
  localparam kind_t K_OROR    = 6'd45;

  localparam err_t E_NONE       = 3'd0;
  localparam err_t E_BAD_ESC    = 3'd1;
  localparam err_t E_UNTERM_STR = 3'd2;
  localparam err_t E_UNTERM_CHR = 3'd3;
  localparam err_t E_UNKNOWN    = 3'd4;

  localparam byte_t KW_TEXT [NUM_KW][KW_MAX] = '{
    '{"C", "h", "a", "r", 8'd0, 8'd0},
    '{"F", "a", "l", "s", "e", 8'd0},
    '{"F", "l", "o", "a", "t", 8'd0},
    '{"I", "n", "t", 8'd0, 8'd0, 8'd0},
    '{"l", "e", "t", 8'd0, 8'd0, 8'd0},
    '{"L", "i", "s", "t", 8'd0, 8'd0},
    '{"m", "a", "t", "c", "h", 8'd0},
    '{"T", "r", "u", "e", 8'd0, 8'd0},
    '{"t", "y", "p", "e", 8'd0, 8'd0},
    '{"U", "n", "i", "t", 8'd0, 8'd0},
    '{"w", "i", "t", "h", 8'd0, 8'd0},
    '{"S", "t", "r", "i", "n", "g"},
    '{"e", "f", "f", "e", "c", "t"}
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd4, 3'd5, 3'd5, 3'd3, 3'd3, 3'd4, 3'd5,
                                             3'd4, 3'd4, 3'd4, 3'd4, 3'd6, 3'd6};

  function automatic logic is_space(input byte_t b);
    return (b == " ") || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_digit(input byte_t b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alpha(input byte_t b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  // K_EOF means the byte is not a single-character symbol
  function automatic kind_t single_kind(input byte_t b);
    kind_t k;
    k = K_EOF;
    case (b)
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      "[": k = K_LBRACK;
      "]": k = K_RBRACK;
      ".": k = K_DOT;
      ";": k = K_SEMI;
      ",": k = K_COMMA;
      "%": k = K_PERCENT;
      "^": k = K_CARET;
      "+": k = K_PLUS;
      "*": k = K_STAR;
      "/": k = K_SLASH;
      "=": k = K_EQ;
      ">": k = K_GT;
      default: k = K_EOF;
    endcase
    return k;
  endfunction

endpackage

// ----- sv/stl_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channels of the tokenizer: source bytes in, tokens out.
// Standalone; the offset, length and line widths of the token channel are parameters.
interface stl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;
  logic       final_byte;
  modport source (output valid, src_byte, final_byte, input ready);
  modport sink (input valid, src_byte, final_byte, output ready);
endinterface

interface stl_out_if #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 16,
  parameter int LENGTH_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [5:0]             token_kind;
  logic [2:0]             error_code;
  logic [OFFSET_BITS-1:0] start_offset;
  logic [LENGTH_BITS-1:0] token_length;
  logic [LINE_BITS-1:0]   line_number;
  logic [LINE_BITS-1:0]   column_number;
  logic                   is_end;
  modport source (output valid, token_kind, error_code, start_offset, token_length,
                  line_number, column_number, is_end, input ready);
  modport sink (input valid, token_kind, error_code, start_offset, token_length,
                line_number, column_number, is_end, output ready);
endinterface

// ----- sv/stl_lex_core.sv -----
`timescale 1ns / 1ps
// Lexer state and one-byte step: from the registered byte it forms up to three
// tokens and the next state combinationally. Uses stl_pkg.
module stl_lex_core #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 16,
  parameter int LENGTH_BITS = 16,
  parameter int TOK_W       = 10 + OFFSET_BITS + LENGTH_BITS + 2 * LINE_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  stl_pkg::byte_t             src_byte,
  input  logic                       final_byte,
  output logic [1:0]                 push_n,
  output logic [2:0][TOK_W-1:0]      push_tok
);
  import stl_pkg::*;

  typedef struct packed {
    kind_t                  kind;
    err_t                   err;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic [LINE_BITS-1:0]   col;
    logic                   is_end;
  } tok_t;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
  localparam logic [LINE_BITS-1:0]   LN_MAX  = '1;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
  localparam logic [LINE_BITS-1:0]   LN_ONE  = LINE_BITS'(1);
  localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

  mode_t                  mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt, ts_r, ts_nxt;
  logic [LINE_BITS-1:0]   ln_r, ln_nxt, col_r, col_nxt;
  logic [NUM_KW-1:0]      kw_r, kw_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic                   esc_r, esc_nxt;
  logic [1:0]             n;
  tok_t [2:0]             res;
  logic                   do_close, do_start;
  kind_t                  sk;

  function automatic logic [OFFSET_BITS-1:0] inc_off(input logic [OFFSET_BITS-1:0] v);
    return (v == OFF_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [LINE_BITS-1:0] inc_ln(input logic [LINE_BITS-1:0] v);
    return (v == LN_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] inc_len(input logic [LENGTH_BITS-1:0] v);
    return (v == LEN_MAX) ? v : v + 1'b1;
  endfunction

  // narrow the keyword candidates by the byte at position pos
  function automatic logic [NUM_KW-1:0] kw_filter(input logic [NUM_KW-1:0] m,
                                                  input logic [LENGTH_BITS-1:0] pos,
                                                  input byte_t b);
    logic [NUM_KW-1:0] r;
    r = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (m[k] && pos < LENGTH_BITS'(KW_LEN[k]))
        r[k] = (KW_TEXT[k][pos[2:0]] == b);
    end
    return r;
  endfunction

  function automatic kind_t ident_kind(input logic [NUM_KW-1:0] m,
                                       input logic [LENGTH_BITS-1:0] len);
    kind_t r;
    r = K_IDENT;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (m[k] && len == LENGTH_BITS'(KW_LEN[k]))
        r = K_KW0 + kind_t'(k);
    end
    return r;
  endfunction

  function automatic logic esc_ok(input byte_t b, input byte_t q);
    return b == "n" || b == "t" || b == "r" || b == "\\" || b == q;
  endfunction

  always_comb begin
    mode_nxt = mode_r;
    off_nxt  = off_r;
    ts_nxt   = ts_r;
    ln_nxt   = ln_r;
    col_nxt  = col_r;
    kw_nxt   = kw_r;
    len_nxt  = len_r;
    esc_nxt  = esc_r;
    n        = 2'd0;
    res      = '0;
    do_close = 1'b0;
    do_start = 1'b0;
    sk       = single_kind(src_byte);

    if (src_byte != 8'd0) begin
      unique case (mode_r)
        M_IDENT: begin
          if (is_alpha(src_byte) || is_digit(src_byte) || src_byte == "_") begin
            kw_nxt  = kw_filter(kw_r, len_r, src_byte);
            len_nxt = inc_len(len_r);
            col_nxt = inc_ln(col_r);
            off_nxt = inc_off(off_r);
          end else begin
            do_close = 1'b1;
            do_start = 1'b1;
          end
        end
        M_INT, M_FRAC: begin
          if (is_digit(src_byte) || (mode_r == M_INT && src_byte == ".")) begin
            len_nxt = inc_len(len_r);
            col_nxt = inc_ln(col_r);
            off_nxt = inc_off(off_r);
            if (src_byte == ".") mode_nxt = M_FRAC;
          end else begin
            do_close = 1'b1;
            do_start = 1'b1;
          end
        end
        M_STR, M_STR_ESC: begin
          if (src_byte == "\n") begin
            do_close = 1'b1;
            do_start = 1'b1;
          end else begin
            len_nxt = inc_len(len_r);
            col_nxt = inc_ln(col_r);
            off_nxt = inc_off(off_r);
            if (mode_r == M_STR_ESC) begin
              if (!esc_ok(src_byte, "\"")) esc_nxt = 1'b1;
              mode_nxt = M_STR;
            end else if (src_byte == "\\") begin
              mode_nxt = M_STR_ESC;
            end else if (src_byte == "\"") begin
              res[0]   = '{K_STR, esc_r ? E_BAD_ESC : E_NONE, ts_r, len_nxt, ln_r,
                           col_nxt, 1'b0};
              n        = 2'd1;
              mode_nxt = M_IDLE;
            end
          end
        end
        M_CHR0, M_CHR_ESC: begin
          len_nxt = inc_len(len_r);
          col_nxt = inc_ln(col_r);
          off_nxt = inc_off(off_r);
          if (mode_r == M_CHR_ESC) begin
            if (!esc_ok(src_byte, "'")) esc_nxt = 1'b1;
            mode_nxt = M_CHR_CLOSE;
          end else begin
            mode_nxt = (src_byte == "\\") ? M_CHR_ESC : M_CHR_CLOSE;
          end
        end
        M_CHR_CLOSE: begin
          if (src_byte == "'") begin
            len_nxt  = inc_len(len_r);
            col_nxt  = inc_ln(col_r);
            off_nxt  = inc_off(off_r);
            res[0]   = '{K_CHAR, esc_r ? E_BAD_ESC : E_NONE, ts_r, len_nxt, ln_r,
                         col_nxt, 1'b0};
            n        = 2'd1;
            mode_nxt = M_IDLE;
          end else begin
            do_close = 1'b1;
            do_start = 1'b1;
          end
        end
        M_COMMENT: begin
          if (src_byte == "\n") begin
            do_start = 1'b1;
          end else begin
            col_nxt = inc_ln(col_r);
            off_nxt = inc_off(off_r);
          end
        end
        M_LT, M_COLON, M_MINUS, M_AMP, M_PIPE: begin
          if (mode_r == M_MINUS && src_byte == "-") begin
            col_nxt  = inc_ln(col_r);
            off_nxt  = inc_off(off_r);
            mode_nxt = M_COMMENT;
          end else if ((mode_r == M_LT && src_byte == ">") ||
                       (mode_r == M_COLON && src_byte == ":") ||
                       (mode_r == M_MINUS && src_byte == ">") ||
                       (mode_r == M_AMP && src_byte == "&") ||
                       (mode_r == M_PIPE && src_byte == "|")) begin
            len_nxt  = inc_len(len_r);
            col_nxt  = inc_ln(col_r);
            off_nxt  = inc_off(off_r);
            res[0]   = '{(mode_r == M_LT) ? K_NE : (mode_r == M_COLON) ? K_DCOLON :
                         (mode_r == M_MINUS) ? K_ARROW : (mode_r == M_AMP) ? K_ANDAND :
                         K_OROR, E_NONE, ts_r, len_nxt, ln_r, col_nxt, 1'b0};
            n        = 2'd1;
            mode_nxt = M_IDLE;
          end else begin
            do_close = 1'b1;
            do_start = 1'b1;
          end
        end
        default: do_start = 1'b1;
      endcase
    end

    // close the pending token with the state as it stands
    if (do_close || src_byte == 8'd0) begin
      priority case (1'b1)
        mode_nxt == M_IDENT: begin
          res[n] = '{ident_kind(kw_nxt, len_nxt), E_NONE, ts_nxt, len_nxt, ln_nxt,
                     col_nxt, 1'b0};
          n = n + 2'd1;
        end
        mode_nxt == M_INT || mode_nxt == M_FRAC || mode_nxt == M_LT ||
        mode_nxt == M_COLON || mode_nxt == M_MINUS || mode_nxt == M_AMP ||
        mode_nxt == M_PIPE: begin
          res[n] = '{(mode_nxt == M_INT) ? K_INT : (mode_nxt == M_FRAC) ? K_FLOAT :
                     (mode_nxt == M_LT) ? K_LT : (mode_nxt == M_COLON) ? K_COLON :
                     (mode_nxt == M_MINUS) ? K_MINUS : (mode_nxt == M_AMP) ? K_AMP :
                     K_PIPE, E_NONE, ts_nxt, len_nxt, ln_nxt, col_nxt, 1'b0};
          n = n + 2'd1;
        end
        mode_nxt == M_STR || mode_nxt == M_STR_ESC: begin
          res[n] = '{K_UNKNOWN, E_UNTERM_STR, ts_nxt, len_nxt, ln_nxt, col_nxt, 1'b0};
          n = n + 2'd1;
        end
        mode_nxt == M_CHR0 || mode_nxt == M_CHR_ESC || mode_nxt == M_CHR_CLOSE: begin
          res[n] = '{K_UNKNOWN, E_UNTERM_CHR, ts_nxt, len_nxt, ln_nxt, col_nxt, 1'b0};
          n = n + 2'd1;
        end
        default: ;
      endcase
      mode_nxt = M_IDLE;
    end

    if (do_start) begin
      mode_nxt = M_IDLE;
      if (is_space(src_byte)) begin
        off_nxt = inc_off(off_nxt);
        if (src_byte == "\n") begin
          ln_nxt  = inc_ln(ln_nxt);
          col_nxt = LN_ONE;
        end else begin
          col_nxt = inc_ln(col_nxt);
        end
      end else begin
        // open a token at this byte
        ts_nxt  = off_nxt;
        len_nxt = LEN_ONE;
        off_nxt = inc_off(off_nxt);
        col_nxt = inc_ln(col_nxt);
        if (is_alpha(src_byte) || src_byte == "_") begin
          kw_nxt   = kw_filter('1, '0, src_byte);
          mode_nxt = M_IDENT;
        end else if (is_digit(src_byte)) begin
          mode_nxt = M_INT;
        end else if (src_byte == "\"" || src_byte == "'") begin
          esc_nxt  = 1'b0;
          mode_nxt = (src_byte == "\"") ? M_STR : M_CHR0;
        end else if (src_byte == "<") begin
          mode_nxt = M_LT;
        end else if (src_byte == ":") begin
          mode_nxt = M_COLON;
        end else if (src_byte == "-") begin
          mode_nxt = M_MINUS;
        end else if (src_byte == "&") begin
          mode_nxt = M_AMP;
        end else if (src_byte == "|") begin
          mode_nxt = M_PIPE;
        end else begin
          res[n] = '{(sk != K_EOF) ? sk : K_UNKNOWN, (sk != K_EOF) ? E_NONE : E_UNKNOWN,
                     ts_nxt, len_nxt, ln_nxt, col_nxt, 1'b0};
          n = n + 2'd1;
        end
      end
    end

    // end of source: close what is pending, then Eof, then back to reset state
    if (src_byte == 8'd0 || final_byte) begin
      if (src_byte != 8'd0) begin
        priority case (1'b1)
          mode_nxt == M_IDENT: begin
            res[n] = '{ident_kind(kw_nxt, len_nxt), E_NONE, ts_nxt, len_nxt, ln_nxt,
                       col_nxt, 1'b0};
            n = n + 2'd1;
          end
          mode_nxt == M_INT || mode_nxt == M_FRAC || mode_nxt == M_LT ||
          mode_nxt == M_COLON || mode_nxt == M_MINUS || mode_nxt == M_AMP ||
          mode_nxt == M_PIPE: begin
            res[n] = '{(mode_nxt == M_INT) ? K_INT : (mode_nxt == M_FRAC) ? K_FLOAT :
                       (mode_nxt == M_LT) ? K_LT : (mode_nxt == M_COLON) ? K_COLON :
                       (mode_nxt == M_MINUS) ? K_MINUS : (mode_nxt == M_AMP) ? K_AMP :
                       K_PIPE, E_NONE, ts_nxt, len_nxt, ln_nxt, col_nxt, 1'b0};
            n = n + 2'd1;
          end
          mode_nxt == M_STR || mode_nxt == M_STR_ESC: begin
            res[n] = '{K_UNKNOWN, E_UNTERM_STR, ts_nxt, len_nxt, ln_nxt, col_nxt, 1'b0};
            n = n + 2'd1;
          end
          mode_nxt == M_CHR0 || mode_nxt == M_CHR_ESC || mode_nxt == M_CHR_CLOSE: begin
            res[n] = '{K_UNKNOWN, E_UNTERM_CHR, ts_nxt, len_nxt, ln_nxt, col_nxt, 1'b0};
            n = n + 2'd1;
          end
          default: ;
        endcase
      end
      res[n]   = '{K_EOF, E_NONE, off_nxt, '0, ln_nxt, col_nxt, 1'b1};
      n        = n + 2'd1;
      mode_nxt = M_IDLE;
      off_nxt  = '0;
      ts_nxt   = '0;
      ln_nxt   = LN_ONE;
      col_nxt  = LN_ONE;
      kw_nxt   = '0;
      len_nxt  = '0;
      esc_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      off_r  <= '0;
      ts_r   <= '0;
      ln_r   <= LN_ONE;
      col_r  <= LN_ONE;
      kw_r   <= '0;
      len_r  <= '0;
      esc_r  <= 1'b0;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      off_r  <= off_nxt;
      ts_r   <= ts_nxt;
      ln_r   <= ln_nxt;
      col_r  <= col_nxt;
      kw_r   <= kw_nxt;
      len_r  <= len_nxt;
      esc_r  <= esc_nxt;
    end
  end

  assign push_n = n;
  always_comb begin
    for (int i = 0; i < 3; i++) push_tok[i] = TOK_W'(res[i]);
  end

endmodule

// ----- sv/stl_res_fifo.sv -----
`timescale 1ns / 1ps
// Four-entry token queue: takes up to three tokens a cycle, hands out one.
// No package dependencies.
module stl_res_fifo #(
  parameter int W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         push_n,
  input  logic [2:0][W-1:0]  push_data,
  output logic               room3,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [W-1:0]       out_data
);
  logic [W-1:0] q_r [4];
  logic [1:0]   wr_r, rd_r;
  logic [2:0]   cnt_r;
  logic         pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = cnt_r != 3'd0;
  assign out_data  = q_r[rd_r];
  // three free slots once this cycle's pop is counted
  assign room3     = (cnt_r - {2'b00, pop}) <= 3'd1;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_n) q_r[wr_r + 2'(i)] <= push_data[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + push_n;
      rd_r  <= rd_r + {1'b0, pop};
      cnt_r <= cnt_r + {1'b0, push_n} - {2'b00, pop};
    end
  end

endmodule

// ----- sv/source_text_tokenizer.sv -----
`timescale 1ns / 1ps
// Top level of the source text tokenizer: input register, lexer step, token queue.
// Depends on stl_pkg, stl_if, stl_lex_core and stl_res_fifo.
//
// Usage: source bytes arrive on in_src (src_byte, final_byte) with valid/ready.
// Each accepted byte lands in an input register; the lexer step then updates the
// lexer state and pushes zero to three tokens into a four-entry queue, which
// drives out_tok. On its way out a token is registered in the queue, after the byte
// that completes it has been held in the input register. One byte is taken per
// cycle as long as the queue has room for three tokens; with a ready receiver,
// bytes that yield one token or none sustain one byte a cycle; more can stall it.
// A zero byte, or final_byte set, ends the source with an Eof token (is_end = 1),
// after which the lexer restarts from line 1, column 1, offset 0.
// Reset (rst_n low, synchronous) empties the input register and the queue and
// returns the lexer to its idle state. When the receiver holds out_tok.ready low
// the queue fills and in_src.ready drops; no token is lost or reordered.
module source_text_tokenizer #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 16,
  parameter int LENGTH_BITS = 16
) (
  input  logic    clk,
  input  logic    rst_n,
  stl_in_if.sink  in_src,
  stl_out_if.source out_tok
);
  import stl_pkg::*;

  localparam int TOK_W = 10 + OFFSET_BITS + LENGTH_BITS + 2 * LINE_BITS;

  typedef struct packed {
    kind_t                  kind;
    err_t                   err;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic [LINE_BITS-1:0]   col;
    logic                   is_end;
  } tok_t;

  logic                   v_r;
  byte_t                  byte_r;
  logic                   fin_r;
  logic                   room3, step;
  logic [1:0]             push_n, push_q;
  logic [2:0][TOK_W-1:0]  push_tok;
  logic [TOK_W-1:0]       head;
  tok_t                   head_t;

  assign step         = v_r && room3;
  assign in_src.ready = !v_r || room3;
  assign push_q       = step ? push_n : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_src.ready) begin
      v_r <= in_src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_src.valid && in_src.ready) begin
      byte_r <= in_src.src_byte;
      fin_r  <= in_src.final_byte;
    end
  end

  stl_lex_core #(
    .OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS), .LENGTH_BITS(LENGTH_BITS),
    .TOK_W(TOK_W)
  ) u_core (
    .clk, .rst_n, .step_en(step), .src_byte(byte_r), .final_byte(fin_r),
    .push_n, .push_tok
  );

  stl_res_fifo #(.W(TOK_W)) u_fifo (
    .clk, .rst_n, .push_n(push_q), .push_data(push_tok), .room3,
    .out_valid(out_tok.valid), .out_ready(out_tok.ready), .out_data(head)
  );

  assign head_t                = tok_t'(head);
  assign out_tok.token_kind    = head_t.kind;
  assign out_tok.error_code    = head_t.err;
  assign out_tok.start_offset  = head_t.start;
  assign out_tok.token_length  = head_t.len;
  assign out_tok.line_number   = head_t.line;
  assign out_tok.column_number = head_t.col;
  assign out_tok.is_end        = head_t.is_end;

endmodule

// ----- sv/stl_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the tokenizer output channel, bound to the top level.
// Depends on stl_pkg and source_text_tokenizer.
module stl_port_checker #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 16,
  parameter int LENGTH_BITS = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [5:0]             token_kind,
  input logic [2:0]             error_code,
  input logic [LENGTH_BITS-1:0] token_length,
  input logic [LINE_BITS-1:0]   line_number,
  input logic                   is_end
);
  import stl_pkg::*;

  // a stalled transaction keeps valid high
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output transaction dropped while stalled");

  a_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_end |-> token_kind == K_EOF && token_length == '0)
    else $error("end token malformed");

  a_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (error_code == E_UNKNOWN || error_code == E_UNTERM_STR ||
                  error_code == E_UNTERM_CHR) |-> token_kind == K_UNKNOWN)
    else $error("error code on a non-unknown token");

  a_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> line_number != '0)
    else $error("line number zero");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind source_text_tokenizer stl_port_checker #(
  .OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS), .LENGTH_BITS(LENGTH_BITS)
) u_stl_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_tok.valid), .out_ready(out_tok.ready),
  .token_kind(out_tok.token_kind), .error_code(out_tok.error_code),
  .token_length(out_tok.token_length), .line_number(out_tok.line_number),
  .is_end(out_tok.is_end)
);

// ----- dv/stl_checker.sv -----
`timescale 1ns / 1ps
// Token checker: watches both channels, runs a lexer predictor on every byte
// transaction and compares each token transaction. Depends on stl_pkg and stl_if.
module stl_checker
  import stl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  stl_in_if         in_m,
  stl_out_if        out_m,
  output int        fail_count,
  output int        tokens_pending
);

  typedef struct packed {
    kind_t        kind;
    err_t         err;
    logic [23:0]  start;
    logic [15:0]  len;
    logic [15:0]  line;
    logic [15:0]  col;
    logic         is_end;
  } token_t;

  token_t      token_q[$];

  mode_t       lx_mode;
  logic [23:0] lx_off, lx_start;
  logic [15:0] lx_line, lx_col, lx_len;
  logic [12:0] lx_kw;
  logic        lx_esc;

  function automatic logic [23:0] sat_off(input logic [23:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [15:0] sat_cnt(input logic [15:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic blank(input byte_t b);
    return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic digit(input byte_t b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic letter(input byte_t b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic kind_t symbol_kind(input byte_t b);
    case (b)
      "(": return K_LPAREN;   ")": return K_RPAREN;
      "{": return K_LBRACE;   "}": return K_RBRACE;
      "[": return K_LBRACK;   "]": return K_RBRACK;
      ".": return K_DOT;      ";": return K_SEMI;
      ",": return K_COMMA;    "%": return K_PERCENT;
      "^": return K_CARET;    "+": return K_PLUS;
      "*": return K_STAR;     "/": return K_SLASH;
      "=": return K_EQ;       ">": return K_GT;
      default: return K_UNKNOWN;
    endcase
  endfunction

  function automatic logic [12:0] narrow_kw(input logic [12:0] m, input logic [15:0] pos,
                                             input byte_t b);
    logic [12:0] r;
    r = '0;
    for (int k = 0; k < NUM_KW; k++)
      if (m[k] && pos < 16'(KW_LEN[k]) && KW_TEXT[k][pos[2:0]] == b) r[k] = 1'b1;
    return r;
  endfunction

  function automatic kind_t word_kind();
    for (int k = 0; k < NUM_KW; k++)
      if (lx_kw[k] && lx_len == 16'(KW_LEN[k])) return K_KW0 + kind_t'(k);
    return K_IDENT;
  endfunction

  task automatic emit_token(input kind_t k, input err_t e);
    token_q.push_back('{k, e, lx_start, lx_len, lx_line, lx_col, 1'b0});
    lx_mode = M_IDLE;
  endtask

  task automatic step_col();
    lx_col = sat_cnt(lx_col);
    lx_off = sat_off(lx_off);
  endtask

  task automatic eat();
    step_col();
    lx_len = sat_cnt(lx_len);
  endtask

  task automatic open_token(input mode_t m);
    lx_start = lx_off;
    lx_len = 16'd1;
    step_col();
    lx_mode = m;
  endtask

  task automatic flush_token();
    case (lx_mode)
      M_IDENT: emit_token(word_kind(), E_NONE);
      M_INT: emit_token(K_INT, E_NONE);
      M_FRAC: emit_token(K_FLOAT, E_NONE);
      M_STR, M_STR_ESC: emit_token(K_UNKNOWN, E_UNTERM_STR);
      M_CHR0, M_CHR_ESC, M_CHR_CLOSE: emit_token(K_UNKNOWN, E_UNTERM_CHR);
      M_LT: emit_token(K_LT, E_NONE);
      M_COLON: emit_token(K_COLON, E_NONE);
      M_MINUS: emit_token(K_MINUS, E_NONE);
      M_AMP: emit_token(K_AMP, E_NONE);
      M_PIPE: emit_token(K_PIPE, E_NONE);
      default: lx_mode = M_IDLE;
    endcase
  endtask

  task automatic begin_token(input byte_t b);
    kind_t k;
    lx_mode = M_IDLE;
    if (blank(b)) begin
      if (b == 8'h0a) begin
        lx_line = sat_cnt(lx_line);
        lx_col = 16'd1;
        lx_off = sat_off(lx_off);
      end else begin
        step_col();
      end
    end else if (letter(b) || b == "_") begin
      lx_kw = narrow_kw('1, 16'd0, b);
      open_token(M_IDENT);
    end else if (digit(b)) begin
      open_token(M_INT);
    end else begin
      case (b)
        8'h22: begin lx_esc = 1'b0; open_token(M_STR); end
        8'h27: begin lx_esc = 1'b0; open_token(M_CHR0); end
        "<": open_token(M_LT);
        ":": open_token(M_COLON);
        "-": open_token(M_MINUS);
        "&": open_token(M_AMP);
        "|": open_token(M_PIPE);
        default: begin
          open_token(M_IDLE);
          k = symbol_kind(b);
          emit_token(k, (k == K_UNKNOWN) ? E_UNKNOWN : E_NONE);
        end
      endcase
    end
  endtask

  task automatic clear_lexer();
    lx_mode = M_IDLE;
    lx_off = 24'd0;
    lx_start = 24'd0;
    lx_line = 16'd1;
    lx_col = 16'd1;
    lx_kw = '0;
    lx_len = 16'd0;
    lx_esc = 1'b0;
  endtask

  task automatic end_source();
    flush_token();
    token_q.push_back('{K_EOF, E_NONE, lx_off, 16'd0, lx_line, lx_col, 1'b1});
    clear_lexer();
  endtask

  task automatic pair_or_flush(input byte_t b, input byte_t second, input kind_t k);
    if (b == second) begin
      eat();
      emit_token(k, E_NONE);
    end else begin
      flush_token();
      begin_token(b);
    end
  endtask

  function automatic logic good_escape(input byte_t b, input byte_t quote);
    return b == "n" || b == "t" || b == "r" || b == 8'h5c || b == quote;
  endfunction

  task automatic lex_byte(input byte_t b, input logic fin);
    if (b == 8'h00) begin
      end_source();
      return;
    end
    case (lx_mode)
      M_IDENT:
        if (letter(b) || digit(b) || b == "_") begin
          lx_kw = narrow_kw(lx_kw, lx_len, b);
          eat();
        end else begin flush_token(); begin_token(b); end
      M_INT:
        if (digit(b)) eat();
        else if (b == ".") begin eat(); lx_mode = M_FRAC; end
        else begin flush_token(); begin_token(b); end
      M_FRAC:
        if (digit(b)) eat();
        else begin flush_token(); begin_token(b); end
      M_STR:
        if (b == 8'h22) begin eat(); emit_token(K_STR, lx_esc ? E_BAD_ESC : E_NONE); end
        else if (b == 8'h5c) begin eat(); lx_mode = M_STR_ESC; end
        else if (b == 8'h0a) begin flush_token(); begin_token(b); end
        else eat();
      M_STR_ESC:
        if (b == 8'h0a) begin flush_token(); begin_token(b); end
        else begin
          if (!good_escape(b, 8'h22)) lx_esc = 1'b1;
          eat();
          lx_mode = M_STR;
        end
      M_CHR0: begin
        eat();
        lx_mode = (b == 8'h5c) ? M_CHR_ESC : M_CHR_CLOSE;
      end
      M_CHR_ESC: begin
        if (!good_escape(b, 8'h27)) lx_esc = 1'b1;
        eat();
        lx_mode = M_CHR_CLOSE;
      end
      M_CHR_CLOSE:
        if (b == 8'h27) begin eat(); emit_token(K_CHAR, lx_esc ? E_BAD_ESC : E_NONE); end
        else begin flush_token(); begin_token(b); end
      M_COMMENT:
        if (b == 8'h0a) begin_token(b);
        else step_col();
      M_LT: pair_or_flush(b, ">", K_NE);
      M_COLON: pair_or_flush(b, ":", K_DCOLON);
      M_MINUS:
        if (b == "-") begin step_col(); lx_mode = M_COMMENT; end
        else pair_or_flush(b, ">", K_ARROW);
      M_AMP: pair_or_flush(b, "&", K_ANDAND);
      M_PIPE: pair_or_flush(b, "|", K_OROR);
      default: begin_token(b);
    endcase
    if (fin) end_source();
  endtask

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    tokens_pending = 0;
    clear_lexer();
  end

  always @(posedge clk) begin
    token_t want;
    if (rst_n) begin
      if (in_m.valid && in_m.ready) lex_byte(in_m.src_byte, in_m.final_byte);
      if (out_m.valid && out_m.ready) begin
        if (token_q.size() == 0) begin
          $display("%0t: unexpected token, actual kind %0d", $time, out_m.token_kind);
          fail_count++;
        end else begin
          want = token_q.pop_front();
          check_field("token_kind", 24'(want.kind), 24'(out_m.token_kind));
          check_field("error_code", 24'(want.err), 24'(out_m.error_code));
          check_field("start_offset", want.start, out_m.start_offset);
          check_field("token_length", 24'(want.len), 24'(out_m.token_length));
          check_field("line_number", 24'(want.line), 24'(out_m.line_number));
          check_field("column_number", 24'(want.col), 24'(out_m.column_number));
          check_field("is_end", 24'(want.is_end), 24'(out_m.is_end));
        end
      end
      tokens_pending = token_q.size();
    end
  end

endmodule

// ----- dv/source_text_tokenizer_tb.sv -----
`timescale 1ns / 1ps
// Testbench top of the source text tokenizer: clock, reset, byte stimulus and
// token back-pressure. Depends on stl_pkg, stl_if, the RTL and stl_checker.
module source_text_tokenizer_tb;
  import stl_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   tokens_pending;
  int   sent_count;
  bit   no_gaps;
  bit   hold_req;
  bit   hold_done;
  bit   drained;

  stl_in_if  in_if();
  stl_out_if out_if();

  source_text_tokenizer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_src  (in_if),
    .out_tok (out_if)
  );

  stl_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_m           (in_if),
    .out_m          (out_if),
    .fail_count     (fail_count),
    .tokens_pending (tokens_pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Token receiver: random stall per transaction, one long hold on request.
  initial begin
    int stall;
    out_if.ready = 0;
    stall = 0;
    hold_done = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_if.ready <= 0;
        repeat (400) @(posedge clk);
        hold_done = 1;
      end else if (stall > 0) begin
        out_if.ready <= 0;
        stall--;
        @(posedge clk);
      end else begin
        out_if.ready <= 1;
        @(posedge clk);
        if (out_if.valid) stall = no_gaps ? 0 : $urandom_range(0, 14);
      end
    end
  end

  task automatic send_byte(input byte_t b, input logic fin);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_if.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1;
    in_if.src_byte <= b;
    in_if.final_byte <= fin;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_text(input string s, input logic fin_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fin_last && i == s.len() - 1);
  endtask

  function automatic byte_t pick(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // Build one lexical fragment, mostly well-formed, sometimes broken.
  task automatic random_fragment(ref byte_t q[$]);
    string word_ch, sym_ch;
    int    n, k;
    word_ch = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
    sym_ch = "(){}[].;,%^+*/=><:-&|";
    case ($urandom_range(0, 10))
      0, 1: begin
        k = $urandom_range(0, NUM_KW - 1);
        for (int i = 0; i < KW_LEN[k]; i++) q.push_back(KW_TEXT[k][i]);
        if ($urandom_range(0, 3) == 0) q.push_back(pick(word_ch));
        q.push_back(" ");
      end
      2: begin
        q.push_back(pick("abcxyzLMT_"));
        n = $urandom_range(0, 7);
        repeat (n) q.push_back(pick(word_ch));
      end
      3: begin
        n = $urandom_range(1, 4);
        repeat (n) q.push_back(pick("0123456789"));
        if ($urandom_range(0, 1)) begin
          q.push_back(".");
          n = $urandom_range(0, 3);
          repeat (n) q.push_back(pick("0123456789"));
        end
      end
      4: begin
        q.push_back(8'h22);
        n = $urandom_range(0, 6);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) begin
            q.push_back(8'h5c);
            q.push_back(pick("ntr\\\"qz0"));
          end else q.push_back(pick("ab c1.-"));
        end
        if ($urandom_range(0, 7) == 0) q.push_back(8'h0a);
        else q.push_back(8'h22);
      end
      5: begin
        q.push_back(8'h27);
        if ($urandom_range(0, 2) == 0) begin
          q.push_back(8'h5c);
          q.push_back(pick("ntr\\'xy"));
        end else q.push_back(pick("ab\n'1 "));
        if ($urandom_range(0, 7) != 0) q.push_back(8'h27);
      end
      6, 7: begin
        n = $urandom_range(1, 3);
        repeat (n) q.push_back(pick(sym_ch));
      end
      8: begin
        q.push_back("-");
        q.push_back("-");
        n = $urandom_range(0, 6);
        repeat (n) q.push_back(byte_t'($urandom_range(1, 255)));
        q.push_back(8'h0a);
      end
      9: begin
        n = $urandom_range(1, 3);
        repeat (n) q.push_back(pick(" \t\n\v\f\r"));
      end
      default: q.push_back(byte_t'($urandom_range(0, 255)));
    endcase
  endtask

  initial begin
    byte_t frag[$];
    sent_count = 0;
    no_gaps = 0;
    hold_req = 0;
    drained = 0;
    rst_n = 0;
    in_if.valid = 0;
    in_if.src_byte = 0;
    in_if.final_byte = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // bad escape in char, string cut by a line feed, char left open,
    // two-byte symbol, float with no fraction, zero byte, high byte, comment,
    // string cut by the end of source
    send_text("'\\q'\"x\n'ab<>1.", 0);
    send_byte(8'h00, 0);
    send_byte(8'hff, 0);
    send_text("--c\n\"\\", 1);
    send_text("::->&&||", 1);

    while (sent_count < 320) begin
      if (sent_count > 150 && !hold_req) hold_req = 1;
      if (sent_count > 240 && !drained) begin
        // stop offering until every expected token has come out
        in_if.valid <= 0;
        wait (tokens_pending == 0);
        repeat (10) @(posedge clk);
        drained = 1;
      end
      frag.delete();
      random_fragment(frag);
      foreach (frag[i])
        send_byte(frag[i], i == frag.size() - 1 && $urandom_range(0, 30) == 0);
    end
    send_byte(8'h00, 0);
    in_if.valid <= 0;

    wait (tokens_pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && tokens_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/stl_pkg.sv
sv/stl_if.sv
sv/stl_lex_core.sv
sv/stl_res_fifo.sv
sv/source_text_tokenizer.sv
sv/stl_checker.sv
dv/stl_checker.sv
dv/source_text_tokenizer_tb.sv
